// ===== rtl/sshpd_pkg.sv =====
// Shared types and constants for the plaintext SSH packet deframer.
// Used by sshpd_parse and ssh_plain_packet_deframer_core; no dependencies.
package sshpd_pkg;

    // Field and counter widths
    localparam int LEN_W      = 19;   // packet and payload byte counters
    localparam int PKT_LEN_W  = 32;   // packet_length field on the wire
    localparam int CFG_ADDR_W = 2;

    // Framing limits fixed by the protocol
    localparam logic [PKT_LEN_W-1:0] MIN_PACKET_LEN  = 32'd5;
    localparam logic [7:0]           MIN_PADDING_LEN = 8'd4;

    // Register reset values
    localparam logic [LEN_W-1:0] MAX_PACKET_RESET  = 19'd35000;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 19'd32768;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PACKET  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_LEN_SHORT   = 3'd0;
    localparam logic [2:0] ERR_LEN_LONG    = 3'd1;
    localparam logic [2:0] ERR_PAD_SHORT   = 3'd2;
    localparam logic [2:0] ERR_PAD_BIG     = 3'd3;
    localparam logic [2:0] ERR_PAYLOAD_BIG = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PADLEN,
        PH_PAYLOAD,
        PH_PADDING,
        PH_DEAD
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] code;
    } result_t;

endpackage

// ===== rtl/ssh_plain_packet_deframer_core.sv =====
// Top level of the plaintext SSH binary packet deframer.
// Depends on sshpd_pkg and sshpd_parse.
//
// Usage:
//   s_* : byte stream in, one packet byte per request (s_tdata[7:0]).
//   m_* : results out. m_tuser is the kind (payload byte, empty packet,
//         framing error), m_tlast flags the last payload byte or the empty
//         packet result, m_tdata carries the byte and the error code.
//   cfg_*: register writes (index 0 max packet length, 1 max payload
//         length); always ready, writes take effect on the next byte.
// Timing: one byte accepted per cycle while s_tready is high. A result appears
//   on m_* in the cycle after its byte is accepted. Padding bytes and the first
//   three length bytes never give a result; the last length byte and the
//   padding-length byte give one only for a framing error or an empty payload.
//   Each result is held in the single output register.
// Stall: while a result waits in the output register and m_tready is low,
//   s_tready is low; when m_tready is high the next byte is taken in the
//   same cycle the waiting result leaves.
// Reset: returns to waiting for a length header, registers go to 35000 and
//   32768. After a framing error one error result is given and all later
//   bytes are accepted and dropped until reset.
module ssh_plain_packet_deframer_core #(
    parameter int MAX_PACKET_BOUND = 262144
) (
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] wire_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [7:0] payload_byte, [10:8] error_code, rest 0
    output logic [1:0]  m_tuser,      // [1:0] result_kind
    output logic        m_tlast,      // last_of_packet
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sshpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sshpd_pkg::LEN_W-1:0]      cfg_data
);

    localparam int LW = sshpd_pkg::LEN_W;

    logic [LW-1:0]      max_pkt_reg;
    logic [LW-1:0]      max_pay_reg;
    logic               m_valid_reg;
    sshpd_pkg::result_t out_reg;

    logic               in_accept;
    logic               res_valid;
    sshpd_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pkt_reg <= sshpd_pkg::MAX_PACKET_RESET;
            max_pay_reg <= sshpd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                sshpd_pkg::REG_MAX_PACKET:  max_pkt_reg <= cfg_data;
                sshpd_pkg::REG_MAX_PAYLOAD: max_pay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Framing state machine
    sshpd_parse #(
        .MAX_PACKET_BOUND(MAX_PACKET_BOUND)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .in_byte        (s_tdata),
        .max_packet_len (max_pkt_reg),
        .max_pay_limit  (max_pay_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_reg.code, out_reg.data};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

// ===== rtl/sshpd_parse.sv =====
// Framing state machine: length header, padding length, payload, padding.
// Depends on sshpd_pkg. Produces at most one result per accepted byte.
module sshpd_parse #(
    parameter int MAX_PACKET_BOUND = 262144
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_accept,
    input  logic [7:0]              in_byte,
    input  logic [sshpd_pkg::LEN_W-1:0] max_packet_len,
    input  logic [sshpd_pkg::LEN_W-1:0] max_pay_limit,
    output logic                    res_valid,
    output sshpd_pkg::result_t      res
);

    localparam int LW = sshpd_pkg::LEN_W;
    localparam int PW = sshpd_pkg::PKT_LEN_W;
    localparam logic [PW-1:0] BOUND = PW'(MAX_PACKET_BOUND);

    sshpd_pkg::phase_t phase_reg, phase_next;
    logic [PW-9:0]     shift_reg, shift_next;   // earlier length bytes
    logic [1:0]        hcount_reg, hcount_next;
    logic [LW-1:0]     pkt_left_reg, pkt_left_next;
    logic [LW-1:0]     pay_left_reg, pay_left_next;

    logic [PW-1:0] length;
    logic [PW-1:0] max_pkt_ext;
    logic [PW-1:0] limit;
    logic [LW-1:0] byte_ext;
    logic [LW-1:0] pay_size;

    // Effective length limit and header/padding arithmetic
    assign length      = {shift_reg, in_byte};
    assign max_pkt_ext = {{(PW-LW){1'b0}}, max_packet_len};
    assign limit       = (max_pkt_ext > BOUND) ? BOUND : max_pkt_ext;
    assign byte_ext    = {{(LW-8){1'b0}}, in_byte};
    assign pay_size    = pkt_left_reg - byte_ext - LW'(1);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sshpd_pkg::PH_HEADER;
            shift_reg    <= '0;
            hcount_reg   <= '0;
            pkt_left_reg <= '0;
            pay_left_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            hcount_reg   <= hcount_next;
            pkt_left_reg <= pkt_left_next;
            pay_left_reg <= pay_left_next;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        hcount_next   = hcount_reg;
        pkt_left_next = pkt_left_reg;
        pay_left_next = pay_left_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (in_accept)
        begin
            case (phase_reg)
                sshpd_pkg::PH_HEADER:
                begin
                    shift_next = {shift_reg[PW-17:0], in_byte};
                    if (hcount_reg != 2'd3)
                    begin
                        hcount_next = hcount_reg + 2'd1;
                    end
                    else
                    begin
                        hcount_next = '0;
                        shift_next  = '0;
                        if (length < sshpd_pkg::MIN_PACKET_LEN)
                        begin
                            phase_next = sshpd_pkg::PH_DEAD;
                            res_valid  = 1'b1;
                            res.kind   = sshpd_pkg::KIND_ERROR;
                            res.code   = sshpd_pkg::ERR_LEN_SHORT;
                        end
                        else if (length > limit)
                        begin
                            phase_next = sshpd_pkg::PH_DEAD;
                            res_valid  = 1'b1;
                            res.kind   = sshpd_pkg::KIND_ERROR;
                            res.code   = sshpd_pkg::ERR_LEN_LONG;
                        end
                        else
                        begin
                            pkt_left_next = length[LW-1:0];
                            phase_next    = sshpd_pkg::PH_PADLEN;
                        end
                    end
                end

                sshpd_pkg::PH_PADLEN:
                begin
                    if (in_byte < sshpd_pkg::MIN_PADDING_LEN)
                    begin
                        phase_next = sshpd_pkg::PH_DEAD;
                        res_valid  = 1'b1;
                        res.kind   = sshpd_pkg::KIND_ERROR;
                        res.code   = sshpd_pkg::ERR_PAD_SHORT;
                    end
                    else if (byte_ext >= pkt_left_reg)
                    begin
                        phase_next = sshpd_pkg::PH_DEAD;
                        res_valid  = 1'b1;
                        res.kind   = sshpd_pkg::KIND_ERROR;
                        res.code   = sshpd_pkg::ERR_PAD_BIG;
                    end
                    else if (pay_size > max_pay_limit)
                    begin
                        phase_next = sshpd_pkg::PH_DEAD;
                        res_valid  = 1'b1;
                        res.kind   = sshpd_pkg::KIND_ERROR;
                        res.code   = sshpd_pkg::ERR_PAYLOAD_BIG;
                    end
                    else
                    begin
                        pkt_left_next = pkt_left_reg - LW'(1);
                        pay_left_next = pay_size;
                        if (pay_size == '0)
                        begin
                            // empty payload: report it, then skip padding
                            phase_next = sshpd_pkg::PH_PADDING;
                            res_valid  = 1'b1;
                            res.kind   = sshpd_pkg::KIND_EMPTY;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            phase_next = sshpd_pkg::PH_PAYLOAD;
                        end
                    end
                end

                sshpd_pkg::PH_PAYLOAD:
                begin
                    pay_left_next = pay_left_reg - LW'(1);
                    pkt_left_next = pkt_left_reg - LW'(1);
                    res_valid     = 1'b1;
                    res.kind      = sshpd_pkg::KIND_PAYLOAD;
                    res.data      = in_byte;
                    res.last      = (pay_left_reg == LW'(1));
                    if (pay_left_reg == LW'(1))
                    begin
                        phase_next = (pkt_left_reg == LW'(1)) ? sshpd_pkg::PH_HEADER
                                                              : sshpd_pkg::PH_PADDING;
                    end
                end

                sshpd_pkg::PH_PADDING:
                begin
                    pkt_left_next = pkt_left_reg - LW'(1);
                    if (pkt_left_reg == LW'(1))
                    begin
                        phase_next = sshpd_pkg::PH_HEADER;
                    end
                end

                default:
                begin
                    // dead after an error: bytes are dropped until reset
                    phase_next = sshpd_pkg::PH_DEAD;
                end
            endcase
        end
    end

endmodule
